// File: rtl/hec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hec_pkg
// Shared widths, types and constants for the horizontal/equatorial converter.
// ----------------------------------------------------------------------------
package hec_pkg;

   // Angle width of all ports and the configuration register.
   localparam int ANGLE_BITS = 24;
   // Distance between the 32-bit internal angle and the port angle.
   localparam int SHIFT_BITS = 32 - ANGLE_BITS;
   // Half an output LSB on the 32-bit internal angle scale.
   localparam logic [31:0] HALF_LSB = (SHIFT_BITS > 0) ? (32'd1 << (SHIFT_BITS - 1)) : 32'd0;

   // Default number of CORDIC iterations.
   localparam int DEF_CORDIC_STAGES = 24;

   // Q30 values (sines, cosines, products) with headroom.
   localparam int Q_W = 34;
   // Vectoring datapath width (input magnitude up to about 2^32 after gain).
   localparam int V_W = 36;
   // Internal angle accumulator width.
   localparam int Z_W = 34;
   // Square root: remainder width and root width, one root bit per step.
   // The partial root is kept scaled by the current trial bit, so it needs
   // the full remainder width until the last steps.
   localparam int N_W = 61;
   localparam int R_W = 61;
   localparam int SQRT_STEPS = 31;

   typedef logic signed [Q_W-1:0] q_type;
   typedef logic signed [Z_W-1:0] z_type;
   typedef logic signed [V_W-1:0] v_type;
   typedef logic signed [ANGLE_BITS-1:0] angle_type;

   localparam q_type CORDIC_START = q_type'(652032874);
   localparam q_type ONE_Q30      = q_type'(1073741824);
   localparam z_type QUARTER_TURN = z_type'(1073741824);
   localparam z_type HALF_TURN    = z_type'(64'd2147483648);

   // Arctangent of 2^-i on the 32-bit binary angle scale.
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   // One rotation CORDIC lane.
   typedef struct packed {
      q_type x;
      q_type y;
      z_type z;
      logic  flip;
   } rot_type;

   // One vectoring CORDIC lane; zero marks a zero input vector.
   typedef struct packed {
      v_type x;
      v_type y;
      z_type z;
      logic  zero;
   } vec_type;

   // Square root lane, carrying the atan2 operands alongside.
   typedef struct packed {
      logic [N_W-1:0] n;
      logic [R_W-1:0] r;
      q_type          y;
      q_type          x;
      q_type          s;
   } sqrt_type;

   typedef struct packed {
      logic      opcode;
      angle_type angle_around;
      angle_type angle_up;
   } req_type;

   typedef struct packed {
      angle_type result_around;
      angle_type result_up;
   } rsp_type;

   // Q30 product, rounded toward minus infinity.
   function automatic q_type mulq(input q_type a, input q_type b);
      logic signed [2*Q_W-1:0] p;
      begin
         p = a * b;
         return p[Q_W+29:30];
      end
   endfunction

endpackage

// File: rtl/horizontal_equatorial_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// horizontal_equatorial_convert
// Converts azimuth/altitude to hour angle/declination and back.
// ----------------------------------------------------------------------------
// Usage: the req channel (req_valid, req_stall, req_data) takes, while
// req_stall is low, one item per cycle: an opcode and two binary angles.
// The rsp channel (rsp_valid, rsp_stall, rsp_data) returns one item per
// request, in order. The csr channel writes the observer latitude;
// csr_ready is always high and the latitude should change only while no
// item is in flight. The pipeline holds three rotation CORDIC rows, four
// product stages, a 31-cell square root row and two vectoring rows.
// Throughput is one item per cycle while no result waits under rsp_stall.
// The whole pipeline advances together; while a result waits under
// rsp_stall the pipe holds and req_stall is raised, and it drops in the
// cycle the result is taken. Reset empties the pipeline and sets the
// latitude to zero.
// ----------------------------------------------------------------------------
module horizontal_equatorial_convert #(
   parameter int CORDIC_STAGES = hec_pkg::DEF_CORDIC_STAGES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hec_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hec_pkg::rsp_type    rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  hec_pkg::angle_type  csr_data
);

   localparam int N = CORDIC_STAGES;
   localparam int DEPTH = 2 * N + hec_pkg::SQRT_STEPS + 8;
   localparam logic signed [2*hec_pkg::Q_W-1:0] ONE_SQ = (2 * hec_pkg::Q_W)'(1) << 60;
   localparam hec_pkg::z_type UP_LIMIT = hec_pkg::z_type'(1) <<< (hec_pkg::ANGLE_BITS - 2);

   logic adv;
   logic vld_ff [DEPTH];
   logic op_ff  [N + 4];

   hec_pkg::angle_type lat_ff;

   // Rotation rows for around angle, up angle and latitude.
   hec_pkg::rot_type ra [N + 1];
   hec_pkg::rot_type ru [N + 1];
   hec_pkg::rot_type rl [N + 1];
   hec_pkg::rot_type ent_a_ff, ent_u_ff, ent_l_ff;
   hec_pkg::rot_type ent_a_in, ent_u_in, ent_l_in;

   hec_pkg::q_type sa_ff, ca_ff, su_ff, cu_ff, sl_ff, cl_ff;
   hec_pkg::q_type p1_y_ff, p1_a_ff, p1_t2x_ff, p1_b1_ff, p1_b2_ff, p1_ca_ff, p1_cu_ff;
   hec_pkg::q_type p2_y_ff, p2_t1x_ff, p2_t2x_ff, p2_b1_ff, p2_t2s_ff;
   hec_pkg::q_type p3_y_ff, p3_x_ff, p3_s_ff;
   hec_pkg::q_type p3_x_in, p3_s_in;

   hec_pkg::sqrt_type sq [hec_pkg::SQRT_STEPS + 1];
   hec_pkg::sqrt_type sq_ff, sq_in;
   logic signed [2*hec_pkg::Q_W-1:0] s_sq;

   hec_pkg::vec_type va [N + 1];
   hec_pkg::vec_type vu [N + 1];
   hec_pkg::vec_type va_ff, vu_ff, va_in, vu_in;

   hec_pkg::rsp_type out_ff, out_in;
   logic [31:0]      around_w;
   hec_pkg::z_type   up_z;

   // The pipe moves unless a finished item is held by the receiver.
   assign adv = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_data = out_ff;
   assign csr_ready = 1'b1;

   // Latitude register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
      end else if (csr_valid) begin
         lat_ff <= csr_data;
      end
   end

   // Valid bits follow the items through every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Opcode travels beside the rotation rows and first product stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0] <= req_data.opcode;
         for (int i = 1; i < N + 4; i++) begin
            op_ff[i] <= op_ff[i-1];
         end
      end
   end

   // Entry: widen to 32-bit angle and fold into the right half plane.
   function automatic hec_pkg::rot_type rot_start(input hec_pkg::angle_type a);
      logic signed [31:0] a32;
      hec_pkg::rot_type   r;
      begin
         a32 = signed'(32'(a) << hec_pkg::SHIFT_BITS);
         r.x = hec_pkg::CORDIC_START;
         r.y = '0;
         r.z = hec_pkg::Z_W'(a32);
         r.flip = 1'b0;
         if (r.z > hec_pkg::QUARTER_TURN) begin
            r.z = r.z - hec_pkg::HALF_TURN;
            r.flip = 1'b1;
         end else if (r.z < -hec_pkg::QUARTER_TURN) begin
            r.z = r.z + hec_pkg::HALF_TURN;
            r.flip = 1'b1;
         end
         return r;
      end
   endfunction

   always_comb begin
      ent_a_in = rot_start(req_data.angle_around);
      ent_u_in = rot_start(req_data.angle_up);
      ent_l_in = rot_start(lat_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_a_ff <= ent_a_in;
         ent_u_ff <= ent_u_in;
         ent_l_ff <= ent_l_in;
      end
   end

   assign ra[0] = ent_a_ff;
   assign ru[0] = ent_u_ff;
   assign rl[0] = ent_l_ff;

   for (genvar k = 0; k < N; k++) begin : g_rot
      hec_rot_cell #(.STAGE(k)) u_rot_a (
         .clock(clock), .en(adv), .cell_in(ra[k]), .cell_out(ra[k+1]));
      hec_rot_cell #(.STAGE(k)) u_rot_u (
         .clock(clock), .en(adv), .cell_in(ru[k]), .cell_out(ru[k+1]));
      hec_rot_cell #(.STAGE(k)) u_rot_l (
         .clock(clock), .en(adv), .cell_in(rl[k]), .cell_out(rl[k+1]));
   end

   // Undo the half-turn fold and form the products in three stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ff <= ra[N].flip ? -ra[N].y : ra[N].y;
         ca_ff <= ra[N].flip ? -ra[N].x : ra[N].x;
         su_ff <= ru[N].flip ? -ru[N].y : ru[N].y;
         cu_ff <= ru[N].flip ? -ru[N].x : ru[N].x;
         sl_ff <= rl[N].flip ? -rl[N].y : rl[N].y;
         cl_ff <= rl[N].flip ? -rl[N].x : rl[N].x;

         p1_y_ff   <= hec_pkg::mulq(sa_ff, cu_ff);
         p1_a_ff   <= hec_pkg::mulq(sl_ff, ca_ff);
         p1_t2x_ff <= hec_pkg::mulq(cl_ff, su_ff);
         p1_b1_ff  <= hec_pkg::mulq(sl_ff, su_ff);
         p1_b2_ff  <= hec_pkg::mulq(cl_ff, cu_ff);
         p1_ca_ff  <= ca_ff;
         p1_cu_ff  <= cu_ff;

         p2_y_ff   <= p1_y_ff;
         p2_t1x_ff <= hec_pkg::mulq(p1_a_ff, p1_cu_ff);
         p2_t2x_ff <= p1_t2x_ff;
         p2_b1_ff  <= p1_b1_ff;
         p2_t2s_ff <= hec_pkg::mulq(p1_b2_ff, p1_ca_ff);

         p3_y_ff <= p2_y_ff;
         p3_x_ff <= p3_x_in;
         p3_s_ff <= p3_s_in;
      end
   end

   // Combine terms by direction and clamp the asin argument.
   always_comb begin
      if (op_ff[N+3]) begin
         p3_x_in = p2_t1x_ff - p2_t2x_ff;
         p3_s_in = p2_b1_ff + p2_t2s_ff;
      end else begin
         p3_x_in = p2_t1x_ff + p2_t2x_ff;
         p3_s_in = p2_b1_ff - p2_t2s_ff;
      end
      if (p3_s_in > hec_pkg::ONE_Q30) begin
         p3_s_in = hec_pkg::ONE_Q30;
      end else if (p3_s_in < -hec_pkg::ONE_Q30) begin
         p3_s_in = -hec_pkg::ONE_Q30;
      end
   end

   // Radicand for the cosine of the up angle.
   always_comb begin
      s_sq = p3_s_ff * p3_s_ff;
      sq_in.n = hec_pkg::N_W'(ONE_SQ - s_sq);
      sq_in.r = '0;
      sq_in.y = p3_y_ff;
      sq_in.x = p3_x_ff;
      sq_in.s = p3_s_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in;
      end
   end

   assign sq[0] = sq_ff;

   for (genvar k = 0; k < hec_pkg::SQRT_STEPS; k++) begin : g_sqrt
      hec_sqrt_cell #(.STEP(k)) u_sqrt (
         .clock(clock), .en(adv), .cell_in(sq[k]), .cell_out(sq[k+1]));
   end

   // Vectoring entry: move the around vector into the right half plane.
   always_comb begin
      va_in.x = hec_pkg::V_W'(sq[hec_pkg::SQRT_STEPS].x);
      va_in.y = hec_pkg::V_W'(sq[hec_pkg::SQRT_STEPS].y);
      va_in.z = '0;
      va_in.zero = (va_in.x == 0) && (va_in.y == 0);
      if (va_in.x < 0) begin
         va_in.x = -va_in.x;
         va_in.y = -va_in.y;
         va_in.z = hec_pkg::HALF_TURN;
      end
      // The final root is at most 2^30, so its low bits carry it whole.
      vu_in.x = $signed({1'b0, sq[hec_pkg::SQRT_STEPS].r[hec_pkg::V_W-2:0]});
      vu_in.y = hec_pkg::V_W'(sq[hec_pkg::SQRT_STEPS].s);
      vu_in.z = '0;
      vu_in.zero = (vu_in.x == 0) && (vu_in.y == 0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         va_ff <= va_in;
         vu_ff <= vu_in;
      end
   end

   assign va[0] = va_ff;
   assign vu[0] = vu_ff;

   for (genvar k = 0; k < N; k++) begin : g_vec
      hec_vec_cell #(.STAGE(k)) u_vec_a (
         .clock(clock), .en(adv), .cell_in(va[k]), .cell_out(va[k+1]));
      hec_vec_cell #(.STAGE(k)) u_vec_u (
         .clock(clock), .en(adv), .cell_in(vu[k]), .cell_out(vu[k+1]));
   end

   // Round both angles to port width; wrap one, clamp the other.
   always_comb begin
      around_w = va[N].zero ? 32'd0 : (32'(va[N].z) + hec_pkg::HALF_LSB);
      out_in.result_around = around_w[31 -: hec_pkg::ANGLE_BITS];
      up_z = vu[N].zero ? '0 : vu[N].z;
      up_z = (up_z + hec_pkg::z_type'({2'b00, hec_pkg::HALF_LSB})) >>> hec_pkg::SHIFT_BITS;
      if (up_z > UP_LIMIT) begin
         up_z = UP_LIMIT;
      end else if (up_z < -UP_LIMIT) begin
         up_z = -UP_LIMIT;
      end
      out_in.result_up = hec_pkg::ANGLE_BITS'(up_z);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

endmodule

// File: rtl/hec_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hec_rot_cell
// One rotation CORDIC iteration with its output register.
// ----------------------------------------------------------------------------
module hec_rot_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              en,
   input  hec_pkg::rot_type  cell_in,
   output hec_pkg::rot_type  cell_out
);

   localparam hec_pkg::z_type STEP_ANGLE = $signed({2'b00, hec_pkg::ATAN_TABLE[STAGE]});

   hec_pkg::rot_type step_ff;
   hec_pkg::rot_type step_in;
   hec_pkg::q_type   xs;
   hec_pkg::q_type   ys;

   // Rotate toward zero residual angle.
   always_comb begin
      xs = cell_in.x >>> STAGE;
      ys = cell_in.y >>> STAGE;
      step_in = cell_in;
      if (cell_in.z >= 0) begin
         step_in.x = cell_in.x - ys;
         step_in.y = cell_in.y + xs;
         step_in.z = cell_in.z - STEP_ANGLE;
      end else begin
         step_in.x = cell_in.x + ys;
         step_in.y = cell_in.y - xs;
         step_in.z = cell_in.z + STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

// File: rtl/hec_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hec_sqrt_cell
// One restoring square root step, producing one root bit per cell.
// ----------------------------------------------------------------------------
module hec_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic               en,
   input  hec_pkg::sqrt_type  cell_in,
   output hec_pkg::sqrt_type  cell_out
);

   localparam logic [hec_pkg::N_W:0] TRIAL_BIT =
      (hec_pkg::N_W + 1)'(1) << (60 - 2 * STEP);

   hec_pkg::sqrt_type       step_ff;
   hec_pkg::sqrt_type       step_in;
   logic [hec_pkg::N_W:0]   trial;
   logic [hec_pkg::N_W:0]   rem;

   // Subtract the trial value when it fits and set the root bit.
   always_comb begin
      trial = (hec_pkg::N_W + 1)'(cell_in.r) + TRIAL_BIT;
      rem = {1'b0, cell_in.n};
      step_in = cell_in;
      if (rem >= trial) begin
         step_in.n = hec_pkg::N_W'(rem - trial);
         step_in.r = hec_pkg::R_W'((hec_pkg::N_W + 1)'(cell_in.r >> 1) + TRIAL_BIT);
      end else begin
         step_in.r = cell_in.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

// File: rtl/hec_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hec_vec_cell
// One vectoring CORDIC iteration with its output register.
// ----------------------------------------------------------------------------
module hec_vec_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              en,
   input  hec_pkg::vec_type  cell_in,
   output hec_pkg::vec_type  cell_out
);

   localparam hec_pkg::z_type STEP_ANGLE = $signed({2'b00, hec_pkg::ATAN_TABLE[STAGE]});

   hec_pkg::vec_type step_ff;
   hec_pkg::vec_type step_in;
   hec_pkg::v_type   xs;
   hec_pkg::v_type   ys;

   // Rotate the vector toward the positive x axis, summing the angle.
   always_comb begin
      xs = cell_in.x >>> STAGE;
      ys = cell_in.y >>> STAGE;
      step_in = cell_in;
      if (cell_in.y < 0) begin
         step_in.x = cell_in.x - ys;
         step_in.y = cell_in.y + xs;
         step_in.z = cell_in.z - STEP_ANGLE;
      end else begin
         step_in.x = cell_in.x + ys;
         step_in.y = cell_in.y - xs;
         step_in.z = cell_in.z + STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

// File: tb/sv/horizontal_equatorial_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// horizontal_equatorial_convert_tb
// Self-checking bench for the horizontal/equatorial coordinate converter.
// A bit-exact predictor computes the expected angle pair for every accepted
// item; a monitor compares each returned item with the oldest prediction.
// Directed corners come first, then random traffic under several idle and
// stall mixes, one long output hold-off and several observer latitudes.
// ----------------------------------------------------------------------------
module horizontal_equatorial_convert_tb;

   localparam int STAGES = 24;
   localparam int LATENCY = 2 * STAGES + 38;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic OP_H2E = 1'b0;
   localparam logic OP_E2H = 1'b1;

   localparam longint ONE30 = 64'sd1073741824;
   localparam longint HALF = 64'sd2147483648;
   localparam longint QUART = 64'sd1073741824;
   localparam longint GAIN_START = 64'sd652032874;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   hec_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   hec_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   hec_pkg::angle_type csr_data = '0;

   horizontal_equatorial_convert #(.CORDIC_STAGES(STAGES)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Expected converted coordinates, oldest first.
   hec_pkg::rsp_type pending_coords[$];
   hec_pkg::angle_type latitude = '0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int errors = 0;
   int items_sent = 0;
   int items_checked = 0;
   longint cycles = 0;
   longint atan_lut[32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   // Q30 product with floor rounding (>>> on signed longint is floor).
   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   // Rotation CORDIC giving sine and cosine in Q30.
   function automatic void rotate_angle(hec_pkg::angle_type ang, output longint s,
                                        output longint c);
      longint z, x, y, nx;
      bit flip;
      z = longint'($signed({ang, 8'h00}));
      x = GAIN_START;
      y = 0;
      flip = 0;
      if (z > QUART) begin
         z -= HALF; flip = 1;
      end else if (z < -QUART) begin
         z += HALF; flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // Vectoring CORDIC atan2 on the 32-bit angle scale.
   function automatic longint vector_angle(longint y, longint x);
      longint z, nx;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x; y = -y; z = HALF;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y < 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b; r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic hec_pkg::rsp_type convert_coords(hec_pkg::req_type rq,
                                                       hec_pkg::angle_type lat);
      longint sa, ca, su, cu, sl, cl, y, x, s, t1, t2, up, root;
      logic [31:0] w;
      hec_pkg::rsp_type r;
      rotate_angle(rq.angle_around, sa, ca);
      rotate_angle(rq.angle_up, su, cu);
      rotate_angle(lat, sl, cl);
      y = qmul(sa, cu);
      t1 = qmul(qmul(sl, ca), cu);
      t2 = qmul(cl, su);
      x = (rq.opcode == OP_E2H) ? t1 - t2 : t1 + t2;
      t1 = qmul(sl, su);
      t2 = qmul(qmul(cl, cu), ca);
      s = (rq.opcode == OP_E2H) ? t1 + t2 : t1 - t2;
      if (s > ONE30) s = ONE30;
      if (s < -ONE30) s = -ONE30;
      root = floor_sqrt(longint'(ONE30 * ONE30 - s * s));
      up = (vector_angle(s, root) + 128) >>> 8;
      if (up > (1 << 22)) up = 1 << 22;
      if (up < -(1 << 22)) up = -(1 << 22);
      w = 32'(vector_angle(y, x));
      w = (w + 32'd128) >> 8;
      r.result_around = w[23:0];
      r.result_up = up[23:0];
      return r;
   endfunction

   // Offer one item and hold it until accepted; valid is dropped only
   // while idling or when the sender stops.
   task automatic send_coords(logic op, hec_pkg::angle_type around,
                              hec_pkg::angle_type up);
      hec_pkg::req_type rq;
      rq.opcode = op;
      rq.angle_around = around;
      rq.angle_up = up;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_coords.push_back(convert_coords(rq, latitude));
      items_sent++;
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_coords.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_latitude(hec_pkg::angle_type lat);
      drain_pipe();
      csr_valid <= 1'b1;
      csr_data <= lat;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      latitude = lat;
   endtask

   function automatic hec_pkg::angle_type rand_around();
      return hec_pkg::angle_type'($urandom);
   endfunction

   function automatic hec_pkg::angle_type rand_up();
      case ($urandom_range(9))
         0: return hec_pkg::angle_type'($urandom);
         1: return hec_pkg::angle_type'(24'sd4194304);
         2: return hec_pkg::angle_type'(-24'sd4194304);
         default: return hec_pkg::angle_type'($signed($urandom_range(8388608)) - 4194304);
      endcase
   endfunction

   // Extremes, both directions, zero vectors and clamp corners.
   task automatic test_directed_corners();
      hec_pkg::angle_type arounds[6] = '{24'sh000000, 24'sh7FFFFF, 24'sh800000,
                                         24'sh400000, 24'shC00000, 24'sh200000};
      hec_pkg::angle_type ups[4] = '{24'sh000000, 24'sh400000, 24'shC00000,
                                     24'shFFFFFF};
      foreach (arounds[i])
         send_coords(i[0] ? OP_E2H : OP_H2E, arounds[i], ups[i % 4]);
      for (int k = 0; k < 4; k++) begin
         send_coords(OP_H2E, 24'sh123456, ups[k]);
         send_coords(OP_E2H, 24'shABCDEF, ups[k]);
      end
      // Angles outside the usual up range wrap as plain binary angles.
      send_coords(OP_E2H, 24'sh555555, 24'sh7FFFFF);
      send_coords(OP_H2E, 24'shAAAAAA, 24'sh800000);
   endtask

   task automatic test_random_traffic(int count, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_coords($urandom_range(1), rand_around(), rand_up());
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   // Receiver holds off long enough for the pipeline to back up.
   task automatic test_backpressure();
      hold_cycles = LATENCY * 2 + 40;
      repeat (LATENCY + 60) send_coords($urandom_range(1), rand_around(), rand_up());
   endtask

   // Output stall: long hold-off first, else random.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each returned item with the oldest prediction.
   always @(posedge clock) begin
      hec_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_coords.size() == 0) begin
            $display("%0t: unexpected item %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_coords.pop_front();
            items_checked++;
            if (rsp_data.result_around !== want.result_around) begin
               $display("%0t: result_around expected %0d actual %0d", $time,
                        want.result_around, rsp_data.result_around);
               errors++;
            end
            if (rsp_data.result_up !== want.result_up) begin
               $display("%0t: result_up expected %0d actual %0d", $time,
                        want.result_up, rsp_data.result_up);
               errors++;
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      write_latitude(24'sh400000);
      test_random_traffic(120, 0, 0);
      write_latitude(24'shC00000);
      test_random_traffic(120, 51, 0);
      write_latitude(24'sh1A2B3C);
      test_random_traffic(120, 0, 51);
      write_latitude(hec_pkg::angle_type'($urandom));
      test_random_traffic(120, 37, 37);
      write_latitude(24'sh000000);
      test_backpressure();
      write_latitude(24'shE5D4C3);
      test_random_traffic(100, 20, 20);
      drain_pipe();
      $display("Checked %0d of %0d items over six latitudes, both directions,",
               items_checked, items_sent);
      $display("with idle, stall and long hold-off phases; %0d mismatches.", errors);
      if (errors == 0 && pending_coords.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/hec_pkg.sv
rtl/hec_rot_cell.sv
rtl/hec_sqrt_cell.sv
rtl/hec_vec_cell.sv
rtl/horizontal_equatorial_convert.sv
tb/sv/horizontal_equatorial_convert_tb.sv
